// File: src/tmss_pkg.sv
// Shared types and constants of the TCP option MSS scanner.
`default_nettype none

package tmss_pkg;

  // Option kinds and lengths.
  localparam logic [7:0] OPT_END     = 8'd0;
  localparam logic [7:0] OPT_NOP     = 8'd1;
  localparam logic [7:0] OPT_MSS     = 8'd2;
  localparam logic [7:0] MSS_OPT_LEN = 8'd4;
  localparam logic [7:0] OPT_MIN_LEN = 8'd2;

  typedef enum logic [2:0] {
    PH_KIND    = 3'd0,
    PH_MSS_LEN = 3'd1,
    PH_MSS_HI  = 3'd2,
    PH_MSS_LO  = 3'd3,
    PH_OPT_LEN = 3'd4,
    PH_SKIP    = 3'd5,
    PH_STOP    = 3'd6
  } scan_phase_t;

  typedef struct packed {
    scan_phase_t phase;
    logic [7:0]  skip_left;
    logic [7:0]  mss_high_byte;
    logic [15:0] mss_running;
    logic        lowered;
    logic        aborted;
  } scan_state_t;

  typedef struct packed {
    logic [7:0]  opt_byte;
    logic        first_byte;
    logic        last_byte;
    logic [15:0] current_mss;
  } scan_item_t;

endpackage

`default_nettype wire

// File: src/tcp_option_mss_scan_unit.sv
// Top level of the TCP option MSS scanner: input register, scan step, result register.
//
// Usage:
//   Option-area bytes of a TCP header enter on the s_axis stream, one byte per
//   transfer. tuser marks the first byte of an area (it restarts the scan and
//   samples current_mss); tlast marks the last byte. Each transfer with tlast
//   produces exactly one result on m_axis: the resulting MSS in tdata, and in
//   tuser whether an MSS option lowered it and whether the scan was stopped
//   early (END, a length below 2 in an unknown option, or a cut-off MSS option).
//   Other bytes produce no result.
//
//   A byte is held in the input register and scanned by the step; for a byte
//   with tlast the result is loaded into the result register on m_axis.
//   Throughput: one byte per cycle unless a tlast byte waits on the result register.
//
//   Reset (rst, synchronous) empties both registers and returns the scan to
//   "expect option kind" with a running MSS of zero.
//   When the receiver stalls, bytes without tlast keep flowing through the
//   scan; a byte with tlast waits in the input register until the result
//   register is free, and s_axis_tready then drops.
`default_nettype none

module tcp_option_mss_scan_unit
  import tmss_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,

  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [7:0] opt_byte, [23:8] current_mss
  input  wire logic        s_axis_tuser,   // [0] first_byte
  input  wire logic        s_axis_tlast,   // last_byte

  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [15:0] result_mss
  output logic [1:0]       m_axis_tuser    // [0] mss_lowered, [1] scan_aborted
);

  // Input register
  logic        in_valid;
  scan_item_t  in_item;

  // Scan state
  scan_state_t state;
  scan_state_t state_next;

  // Result register
  logic        out_valid;
  logic [15:0] out_mss;
  logic        out_lowered;
  logic        out_aborted;

  logic accept;
  logic consume;
  logic load_out;

  // A byte with tlast needs the result register free; others always pass.
  assign consume  = in_valid && (!in_item.last_byte || !out_valid || m_axis_tready);
  assign load_out = consume && in_item.last_byte;
  assign s_axis_tready = !in_valid || consume;
  assign accept   = s_axis_tvalid && s_axis_tready;

  tmss_step u_step (
    .state_cur (state),
    .item      (in_item),
    .state_out (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (accept) begin
      in_valid <= 1'b1;
    end else if (consume) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item.opt_byte    <= s_axis_tdata[7:0];
      in_item.current_mss <= s_axis_tdata[23:8];
      in_item.first_byte  <= s_axis_tuser;
      in_item.last_byte   <= s_axis_tlast;
    end
  end

  // all-zero state: phase PH_KIND, running MSS zero
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (consume) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_mss     <= state_next.mss_running;
      out_lowered <= state_next.lowered;
      out_aborted <= state_next.aborted;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_mss;
  assign m_axis_tuser  = {out_aborted, out_lowered};

`ifndef SYNTHESIS
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> in_valid && in_item.last_byte && out_valid && !m_axis_tready)
    else $error("input stalled without a blocked result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load_out |-> !out_valid || m_axis_tready)
    else $error("result register overwritten while held");

  a_stop_after_last: assert property (@(posedge clk) disable iff (rst)
    load_out |=> state.phase == PH_STOP && state.skip_left == 8'd0)
    else $error("scan not stopped after last byte");

  a_skip_phase: assert property (@(posedge clk) disable iff (rst)
    state.skip_left != 8'd0 |-> state.phase == PH_SKIP)
    else $error("skip count left outside skip phase");
`endif

endmodule

`default_nettype wire

// File: src/tmss_step.sv
// Next-state logic of the option scan for one option byte.
`default_nettype none

module tmss_step
  import tmss_pkg::*;
(
  input  scan_state_t state_cur,
  input  scan_item_t  item,
  output scan_state_t state_out
);

  function automatic scan_state_t take_kind(input scan_state_t s, input logic [7:0] b);
    scan_state_t r;
    r = s;
    if (b == OPT_END) begin
      r.phase   = PH_STOP;
      r.aborted = 1'b1;
    end else if (b == OPT_NOP) begin
      r.phase = PH_KIND;
    end else if (b == OPT_MSS) begin
      r.phase = PH_MSS_LEN;
    end else begin
      r.phase = PH_OPT_LEN;
    end
    return r;
  endfunction

  scan_state_t st;
  scan_state_t nx;
  logic [15:0] mss_val;
  logic [7:0]  skip_dec;
  logic [7:0]  skip_len;

  always_comb begin
    st = state_cur;
    if (item.first_byte) begin
      st             = '0;
      st.phase       = PH_KIND;
      st.mss_running = item.current_mss;
    end

    nx       = st;
    mss_val  = {st.mss_high_byte, item.opt_byte};
    skip_dec = (st.skip_left != 8'd0) ? (st.skip_left - 8'd1) : st.skip_left;
    skip_len = item.opt_byte - OPT_MIN_LEN;

    unique case (st.phase)
      PH_KIND: begin
        nx = take_kind(st, item.opt_byte);
      end
      PH_MSS_LEN: begin
        if (item.opt_byte == MSS_OPT_LEN) begin
          nx.phase = PH_MSS_HI;
        end else begin
          // wrong MSS length: reread this byte as a kind
          nx = take_kind(st, item.opt_byte);
        end
      end
      PH_MSS_HI: begin
        nx.mss_high_byte = item.opt_byte;
        nx.phase         = PH_MSS_LO;
      end
      PH_MSS_LO: begin
        if (mss_val < st.mss_running) begin
          nx.mss_running = mss_val;
          nx.lowered     = 1'b1;
        end
        nx.phase = PH_KIND;
      end
      PH_OPT_LEN: begin
        if (item.opt_byte < OPT_MIN_LEN) begin
          nx.phase   = PH_STOP;
          nx.aborted = 1'b1;
        end else begin
          nx.skip_left = skip_len;
          nx.phase     = (skip_len == 8'd0) ? PH_KIND : PH_SKIP;
        end
      end
      PH_SKIP: begin
        nx.skip_left = skip_dec;
        if (skip_dec == 8'd0) begin
          nx.phase = PH_KIND;
        end
      end
      default: begin
        nx.phase = PH_STOP;
      end
    endcase

    if (item.last_byte) begin
      // MSS option cut off by the end of the area
      if (nx.phase == PH_MSS_LEN || nx.phase == PH_MSS_HI || nx.phase == PH_MSS_LO) begin
        nx.aborted = 1'b1;
      end
      nx.phase     = PH_STOP;
      nx.skip_left = 8'd0;
    end

    state_out = nx;
  end

endmodule

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the TCP option MSS scanner stream unit.
`default_nettype none

module testbench;
  import tmss_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 10;
  localparam int HOLD_CYCLES  = 200;
  localparam int PHASE_ITEMS  = 300;
  localparam int MAX_AREA     = 40;

  typedef struct packed {
    logic [15:0] mss;
    logic        lowered;
    logic        aborted;
  } mss_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // [7:0] opt_byte, [23:8] current_mss
  logic        s_axis_tuser = 1'b0; // [0] first_byte
  logic        s_axis_tlast = 1'b0; // last_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [15:0] result_mss
  logic [1:0]  m_axis_tuser;        // [0] mss_lowered, [1] scan_aborted

  // scanner state as the checker sees it, reset values
  scan_phase_t scan_ph    = PH_KIND;
  logic [7:0]  skip_cnt   = '0;
  logic [7:0]  mss_hi     = '0;
  logic [15:0] run_mss    = '0;
  logic        lower_flag = 1'b0;
  logic        abort_flag = 1'b0;

  mss_result_t mss_expect_q[$];
  mss_result_t oldest_mss;
  logic [7:0]  area_q[$];
  int          mismatch_count = 0;
  int          byte_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_asks = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  tcp_option_mss_scan_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // long receiver hold-off, started on request
  always @(posedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result side: compare each transfer with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (mss_expect_q.size() == 0) begin
        $display("%0t: unexpected result mss=%h lowered=%b aborted=%b", $time,
                 m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]);
        mismatch_count++;
      end else begin
        oldest_mss = mss_expect_q.pop_front();
        if (m_axis_tdata !== oldest_mss.mss) begin
          $display("%0t: result_mss expected %h actual %h", $time,
                   oldest_mss.mss, m_axis_tdata);
          mismatch_count++;
        end
        if (m_axis_tuser[0] !== oldest_mss.lowered) begin
          $display("%0t: mss_lowered expected %b actual %b", $time,
                   oldest_mss.lowered, m_axis_tuser[0]);
          mismatch_count++;
        end
        if (m_axis_tuser[1] !== oldest_mss.aborted) begin
          $display("%0t: scan_aborted expected %b actual %b", $time,
                   oldest_mss.aborted, m_axis_tuser[1]);
          mismatch_count++;
        end
      end
    end
    m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic take_kind(input logic [7:0] kind);
    if (kind == OPT_END) begin
      scan_ph = PH_STOP;
      abort_flag = 1'b1;
    end else if (kind == OPT_NOP) begin
      scan_ph = PH_KIND;
    end else if (kind == OPT_MSS) begin
      scan_ph = PH_MSS_LEN;
    end else begin
      scan_ph = PH_OPT_LEN;
    end
  endtask

  task automatic predict_scan(input logic [7:0] b, input logic first,
                              input logic last, input logic [15:0] cur);
    logic [15:0] opt_mss;
    if (first) begin
      scan_ph = PH_KIND;
      skip_cnt = '0;
      mss_hi = '0;
      run_mss = cur;
      lower_flag = 1'b0;
      abort_flag = 1'b0;
    end
    case (scan_ph)
      PH_KIND: take_kind(b);
      PH_MSS_LEN: begin
        if (b == MSS_OPT_LEN) scan_ph = PH_MSS_HI;
        else take_kind(b);
      end
      PH_MSS_HI: begin
        mss_hi = b;
        scan_ph = PH_MSS_LO;
      end
      PH_MSS_LO: begin
        opt_mss = {mss_hi, b};
        if (opt_mss < run_mss) begin
          run_mss = opt_mss;
          lower_flag = 1'b1;
        end
        scan_ph = PH_KIND;
      end
      PH_OPT_LEN: begin
        if (b < OPT_MIN_LEN) begin
          scan_ph = PH_STOP;
          abort_flag = 1'b1;
        end else begin
          skip_cnt = b - OPT_MIN_LEN;
          scan_ph = (skip_cnt == 0) ? PH_KIND : PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (skip_cnt != 0) skip_cnt = skip_cnt - 8'd1;
        if (skip_cnt == 0) scan_ph = PH_KIND;
      end
      default: scan_ph = PH_STOP;
    endcase
    if (last) begin
      // an MSS option still open at the end of the area is a truncation
      if (scan_ph == PH_MSS_LEN || scan_ph == PH_MSS_HI || scan_ph == PH_MSS_LO)
        abort_flag = 1'b1;
      scan_ph = PH_STOP;
      skip_cnt = '0;
      mss_expect_q.push_back('{run_mss, lower_flag, abort_flag});
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic first,
                           input logic last, input logic [15:0] cur);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {cur, b};
    s_axis_tuser  <= first;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    predict_scan(b, first, last, cur);
    byte_count++;
  endtask

  // one option area: mostly well-formed options with random content
  task automatic gen_area();
    int n_opts;
    int pick;
    int opt_len;
    logic [7:0] len_byte;
    area_q.delete();
    n_opts = $urandom_range(1, 6);
    for (int k = 0; k < n_opts; k++) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        area_q.push_back(OPT_NOP);
      end else if (pick < 20) begin
        area_q.push_back(OPT_END);
        repeat ($urandom_range(0, 3)) area_q.push_back(8'($urandom));
      end else if (pick < 50) begin
        area_q.push_back(OPT_MSS);
        area_q.push_back(MSS_OPT_LEN);
        area_q.push_back(8'($urandom));
        area_q.push_back(8'($urandom));
      end else if (pick < 56) begin
        // MSS kind with a wrong length: the length is taken as the next kind
        area_q.push_back(OPT_MSS);
        do len_byte = 8'($urandom); while (len_byte == MSS_OPT_LEN);
        area_q.push_back(len_byte);
      end else if (pick < 90) begin
        area_q.push_back(8'($urandom_range(3, 255)));
        opt_len = ($urandom_range(9) == 0) ? $urandom_range(2, 255) : $urandom_range(2, 10);
        area_q.push_back(8'(opt_len));
        for (int j = 2; j < opt_len && area_q.size() < MAX_AREA; j++)
          area_q.push_back(8'($urandom));
      end else if (pick < 95) begin
        area_q.push_back(8'($urandom_range(3, 255)));
        area_q.push_back(8'($urandom_range(0, 1)));
      end else begin
        area_q.push_back(8'($urandom));
      end
    end
    if ($urandom_range(4) == 0)
      while (area_q.size() > 1 && $urandom_range(1) == 0) void'(area_q.pop_back());
    while (area_q.size() > MAX_AREA) void'(area_q.pop_back());
  endtask

  task automatic send_area();
    logic [15:0] cur;
    case ($urandom_range(3))
      0: cur = 16'h0000;
      1: cur = 16'hFFFF;
      default: cur = 16'($urandom);
    endcase
    for (int i = 0; i < area_q.size(); i++)
      send_byte(area_q[i], i == 0, i == area_q.size() - 1,
                (i == 0) ? cur : 16'($urandom));
  endtask

  task automatic test_before_first();
    // scan runs on the reset state, running MSS is zero
    send_byte(OPT_NOP, 1'b0, 1'b0, 16'hFFFF);
    send_byte(OPT_NOP, 1'b0, 1'b1, 16'hFFFF);
  endtask

  task automatic test_mss_option();
    send_byte(OPT_MSS, 1'b1, 1'b0, 16'hFFFF);
    send_byte(MSS_OPT_LEN, 1'b0, 1'b0, 16'h0000);
    send_byte(8'h12, 1'b0, 1'b0, 16'h0000);
    send_byte(8'h34, 1'b0, 1'b1, 16'h0000);
    // larger value leaves the MSS alone
    send_byte(OPT_MSS, 1'b1, 1'b0, 16'h0000);
    send_byte(MSS_OPT_LEN, 1'b0, 1'b0, 16'hFFFF);
    send_byte(8'hFF, 1'b0, 1'b0, 16'hFFFF);
    send_byte(8'hFF, 1'b0, 1'b1, 16'hFFFF);
  endtask

  task automatic test_end_option();
    send_byte(OPT_END, 1'b1, 1'b0, 16'h1000);
    send_byte(8'hFF, 1'b0, 1'b1, 16'h0000);
  endtask

  task automatic test_malformed_lengths();
    // MSS kind with length 3: the 3 becomes an unknown kind
    send_byte(OPT_MSS, 1'b1, 1'b0, 16'h8000);
    send_byte(8'h03, 1'b0, 1'b0, 16'h0000);
    send_byte(8'h02, 1'b0, 1'b0, 16'h0000);
    send_byte(OPT_NOP, 1'b0, 1'b1, 16'h0000);
    // unknown option with length below two stops the scan
    send_byte(8'hFE, 1'b1, 1'b0, 16'h4321);
    send_byte(8'h01, 1'b0, 1'b1, 16'h0000);
    // unknown option running past the area is not an abort
    send_byte(8'h1E, 1'b1, 1'b0, 16'h0555);
    send_byte(8'h0A, 1'b0, 1'b0, 16'h0000);
    send_byte(8'hAA, 1'b0, 1'b1, 16'h0000);
  endtask

  task automatic test_truncation_and_trailing();
    send_byte(OPT_MSS, 1'b1, 1'b0, 16'h0600);
    send_byte(MSS_OPT_LEN, 1'b0, 1'b0, 16'h0000);
    send_byte(8'h05, 1'b0, 1'b1, 16'h0000);
    // trailing bytes without a new first byte repeat the held result
    send_byte(OPT_MSS, 1'b0, 1'b0, 16'h0000);
    send_byte(OPT_END, 1'b0, 1'b1, 16'h0000);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    hold_asks <= hold_asks + 1;
    repeat (40) begin
      send_byte(OPT_NOP, 1'b1, 1'b0, 16'($urandom));
      send_byte(OPT_NOP, 1'b0, 1'b1, 16'($urandom));
    end
  endtask

  task automatic run_random_phase(input int n_items, input int idle_pct,
                                  input int stall_pct);
    int stop_at;
    send_idle_pct = idle_pct;
    recv_stall_pct <= stall_pct;
    stop_at = byte_count + n_items;
    while (byte_count < stop_at) begin
      if ($urandom_range(9) == 0) begin
        // loose bytes with random markers
        repeat ($urandom_range(1, 5))
          send_byte(8'($urandom), $urandom_range(7) == 0, $urandom_range(7) == 0,
                    16'($urandom));
      end else begin
        gen_area();
        send_area();
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_before_first();
    test_mss_option();
    test_end_option();
    test_malformed_lengths();
    test_truncation_and_trailing();
    test_backpressure();
    run_random_phase(PHASE_ITEMS, 0, 0);
    run_random_phase(PHASE_ITEMS, 52, 0);
    run_random_phase(PHASE_ITEMS, 0, 52);
    run_random_phase(PHASE_ITEMS, 34, 34);

    s_axis_tvalid <= 1'b0;
    while (mss_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
src/tmss_pkg.sv
src/tmss_step.sv
src/tcp_option_mss_scan_unit.sv
sim/testbench.sv
